@@ rtl/bcsp_pkg.sv @@
// Shared types and constants of the boot command stream parser.
`default_nettype none
package bcsp_pkg;

	localparam int unsigned HdrLen    = 16;
	localparam int unsigned IdxW      = 4;
	localparam int unsigned SkipW     = 33;
	localparam logic [7:0]  SUM_SEED  = 8'd90;

	// Opcodes found in header byte 1
	localparam logic [7:0] OP_LOAD = 8'h02;
	localparam logic [7:0] OP_FILL = 8'h03;
	localparam logic [7:0] OP_JUMP = 8'h04;
	localparam logic [7:0] OP_CALL = 8'h05;

	// Command kinds reported per record
	localparam logic [2:0] KIND_LOAD    = 3'd0;
	localparam logic [2:0] KIND_FILL    = 3'd1;
	localparam logic [2:0] KIND_CALL    = 3'd2;
	localparam logic [2:0] KIND_JUMP    = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;

	// One decoded command record
	typedef struct packed {
		logic [2:0]  command_kind;
		logic [7:0]  raw_opcode;
		logic [31:0] target_address;
		logic [31:0] middle_word;
		logic [31:0] last_word;
		logic        checksum_ok;
	} rec_t;

endpackage
`default_nettype wire

@@ rtl/bcsp_parse.sv @@
// Input register, header collection, checksum, opcode decode and payload skip.
`default_nettype none
module bcsp_parse
	import bcsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	output logic            rec_valid,
	input  wire logic       rec_ready,
	output rec_t            rec
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	logic [7:0]           hdr_q [HdrLen];
	logic [IdxW-1:0]      idx_q;
	logic [7:0]           sum_q;
	logic [SkipW-1:0]     skip_q;
	logic                 stopped_q;

	logic                 collect;
	logic                 produce;
	logic                 advance;
	logic [7:0]           sum_next;
	logic [31:0]          mid_word;
	logic [SkipW-1:0]     load_skip;

	// Classify the byte held in the input register
	assign collect  = valid_s1 && !stopped_q && (skip_q == '0);
	assign produce  = collect && (idx_q == IdxW'(HdrLen - 1));
	assign advance  = valid_s1 && (!produce || rec_ready);
	assign s_tready = !valid_s1 || advance;
	assign rec_valid = produce;

	assign sum_next  = sum_q + byte_s1;
	assign mid_word  = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
	assign load_skip = ({1'b0, mid_word} + SkipW'(15)) & ~SkipW'(15);

	// Assemble the record from the stored bytes plus the final byte
	always_comb begin
		rec.raw_opcode     = hdr_q[1];
		rec.target_address = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
		rec.middle_word    = mid_word;
		rec.last_word      = {byte_s1, hdr_q[14], hdr_q[13], hdr_q[12]};
		rec.checksum_ok    = (sum_next == hdr_q[0]);
		case (hdr_q[1])
			OP_LOAD: rec.command_kind = KIND_LOAD;
			OP_FILL: rec.command_kind = KIND_FILL;
			OP_CALL: rec.command_kind = KIND_CALL;
			OP_JUMP: rec.command_kind = KIND_JUMP;
			default: rec.command_kind = KIND_UNKNOWN;
		endcase
	end

	// Input register: take a new transaction whenever the stage is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Header byte store
	always_ff @(posedge clk) begin
		if (advance && collect) begin
			hdr_q[idx_q] <= byte_s1;
		end
	end

	// Parser state: index, running sum, skip count, stop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			sum_q     <= SUM_SEED;
			skip_q    <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				idx_q     <= '0;
				sum_q     <= SUM_SEED;
				skip_q    <= '0;
				stopped_q <= 1'b0;
			end else if (stopped_q) begin
				stopped_q <= 1'b1;
			end else if (skip_q != '0) begin
				skip_q <= skip_q - SkipW'(1);
			end else if (produce) begin
				idx_q <= '0;
				sum_q <= SUM_SEED;
				if (rec.command_kind == KIND_LOAD) begin
					skip_q <= load_skip;
				end
				if (rec.command_kind == KIND_UNKNOWN) begin
					stopped_q <= 1'b1;
				end
			end else begin
				idx_q <= idx_q + IdxW'(1);
				if (idx_q != '0) begin
					sum_q <= sum_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bcsp_out.sv @@
// Output register that holds one record until the downstream side takes it.
`default_nettype none
module bcsp_out
	import bcsp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic rec_valid,
	output logic      rec_ready,
	input  wire rec_t rec,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output rec_t      m_rec
);

	logic valid_q;
	rec_t rec_q;

	// Free when empty or being drained this cycle
	assign rec_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_rec     = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			rec_q <= rec;
		end
	end

endmodule
`default_nettype wire

@@ rtl/boot_command_stream_parser.sv @@
// Top level of the boot command stream parser.
// Takes one section byte per transaction and emits one record per completed
// 16-byte command header (load, fill, call, jump, or unknown opcode, with a
// header checksum flag). Each byte passes an input register, then the
// index/sum/skip update and opcode decode, then an output register, so a
// byte may enter every cycle unless a waiting record holds it back, and a
// record is registered from its last header byte in the input register. A
// record still waiting in the output register holds back only the byte that
// completes the next header. Load payloads (length rounded up to 16) are
// consumed silently; after an unknown opcode the rest of the section is
// dropped. tlast on the input ends a section and returns the parser to idle.
`default_nettype none
module boot_command_stream_parser
	import bcsp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tlast,   // last_in_section
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,   // [7:0] raw_opcode, [39:8] target_address,
	                                     // [71:40] middle_word, [103:72] last_word,
	                                     // [104] checksum_ok, rest zero
	output logic [2:0]        m_tuser    // [2:0] command_kind
);

	logic rec_valid;
	logic rec_ready;
	rec_t rec;
	rec_t m_rec;

	bcsp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	bcsp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_rec     (m_rec)
	);

	// Pack the record onto the stream
	assign m_tdata = {7'd0, m_rec.checksum_ok, m_rec.last_word, m_rec.middle_word,
		m_rec.target_address, m_rec.raw_opcode};
	assign m_tuser = m_rec.command_kind;

endmodule
`default_nettype wire

@@ tb/sv/boot_command_stream_parser_tb.sv @@
// Self-checking testbench for the boot command stream parser.
`default_nettype none
module boot_command_stream_parser_tb
	import bcsp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_section;
	} section_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = '0;
	logic         s_tlast  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [2:0]   m_tuser;

	boot_command_stream_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Section bytes waiting to be sent and decoded records waiting to arrive
	section_item_t section_q[$];
	rec_t          record_q[$];
	int            total_items   = 0;
	int            accepted_cnt  = 0;
	int            records_seen  = 0;
	int            fail_cnt      = 0;

	// Parser state as predicted from the accepted bytes
	logic [7:0]  hdr_buf [HdrLen];
	logic [3:0]  hdr_pos   = '0;
	logic [7:0]  hdr_sum   = SUM_SEED;
	logic [32:0] skip_left = '0;
	logic        halted    = 1'b0;

	// Advance the predicted parser by one byte and queue any record it yields
	task automatic parse_byte(input logic [7:0] b, input logic last);
		rec_t rec;
		if (halted) begin
			// drop the rest of the section
		end else if (skip_left != 0) begin
			skip_left = skip_left - 33'd1;
		end else begin
			hdr_buf[hdr_pos] = b;
			if (hdr_pos != 0)
				hdr_sum = hdr_sum + b;
			if (hdr_pos == 4'(HdrLen - 1)) begin
				rec.raw_opcode     = hdr_buf[1];
				rec.target_address = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
				rec.middle_word    = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
				rec.last_word      = {hdr_buf[15], hdr_buf[14], hdr_buf[13], hdr_buf[12]};
				rec.checksum_ok    = (hdr_sum == hdr_buf[0]);
				case (hdr_buf[1])
					OP_LOAD: begin
						rec.command_kind = KIND_LOAD;
						skip_left = ({1'b0, rec.middle_word} + 33'd15) & ~33'd15;
					end
					OP_FILL: rec.command_kind = KIND_FILL;
					OP_CALL: rec.command_kind = KIND_CALL;
					OP_JUMP: rec.command_kind = KIND_JUMP;
					default: begin
						rec.command_kind = KIND_UNKNOWN;
						halted = 1'b1;
					end
				endcase
				record_q.push_back(rec);
				hdr_pos = '0;
				hdr_sum = SUM_SEED;
			end else begin
				hdr_pos = hdr_pos + 4'd1;
			end
		end
		if (last) begin
			hdr_pos   = '0;
			hdr_sum   = SUM_SEED;
			skip_left = '0;
			halted    = 1'b0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		section_q.push_back('{b, 1'b0});
		total_items++;
	endtask

	// Mark the most recent byte as the end of its section
	task automatic end_section();
		section_q[section_q.size() - 1].last_in_section = 1'b1;
	endtask

	// Queue one 16-byte command header, with a correct or corrupted checksum
	task automatic add_header(input logic [7:0] op, input logic [31:0] addr,
			input logic [31:0] mid, input logic [31:0] tail, input bit good);
		logic [7:0] hb [HdrLen];
		logic [7:0] sum;
		hb[1] = op;
		hb[2] = 8'($urandom);
		hb[3] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			hb[4 + i]  = addr[8*i +: 8];
			hb[8 + i]  = mid[8*i +: 8];
			hb[12 + i] = tail[8*i +: 8];
		end
		sum = SUM_SEED;
		for (int i = 1; i < HdrLen; i++)
			sum = sum + hb[i];
		hb[0] = good ? sum : sum ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < HdrLen; i++)
			push_byte(hb[i]);
	endtask

	task automatic add_noise(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom));
	endtask

	function automatic logic [7:0] unknown_opcode();
		logic [7:0] op;
		do
			op = 8'($urandom);
		while (op >= OP_LOAD && op <= OP_CALL);
		return op;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: bursts of random length separated by random gaps
	int send_burst = 1;
	int send_gap   = 0;

	always @(posedge clk) begin
		section_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (section_q.size() != 0) begin
					nxt = section_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data_byte;
					s_tlast  <= nxt.last_in_section;
					if (send_burst > 1) begin
						send_burst--;
					end else begin
						send_burst = $urandom_range(1, 24);
						send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern cycling through modes, plus long hold-offs
	logic [8:0] rx_phase   = '0;
	int         hold_left  = 0;
	int         holds_done = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 9'd1;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && records_seen >= 12 * (holds_done + 1)) begin
				// hold off long enough for the parser to back up into its input
				holds_done++;
				hold_left = 200;
				m_tready <= 1'b0;
			end else begin
				case (rx_phase[8:7])
					2'd0:    m_tready <= 1'b1;
					2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
					2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Monitor: compare every record transaction with the oldest expectation
	always @(posedge clk) begin
		rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			records_seen++;
			if (record_q.size() == 0) begin
				$error("record with no expectation: kind %0d opcode 0x%0h",
					m_tuser, m_tdata[7:0]);
				fail_cnt++;
			end else begin
				want = record_q.pop_front();
				check_field("command_kind", 32'(want.command_kind), 32'(m_tuser));
				check_field("raw_opcode", 32'(want.raw_opcode), 32'(m_tdata[7:0]));
				check_field("target_address", want.target_address, m_tdata[39:8]);
				check_field("middle_word", want.middle_word, m_tdata[71:40]);
				check_field("last_word", want.last_word, m_tdata[103:72]);
				check_field("checksum_ok", 32'(want.checksum_ok), 32'(m_tdata[104]));
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int      ncmd;
		int      pick;
		int      plen;
		bit      open;
		logic [7:0]  op;
		logic [31:0] mid;

		arst_n = 1'b0;

		// Load of zero length with extreme address, section ends on a fill
		add_header(OP_LOAD, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
		add_header(OP_FILL, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		end_section();
		// Call and jump, one with a bad checksum; header completes on section end
		add_header(OP_CALL, 32'h8000_0000, 32'h1234_5678, 32'hA5A5_5A5A, 1'b0);
		add_header(OP_JUMP, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 1'b1);
		end_section();
		// Load of 17 bytes skips a 32-byte payload, then a header follows
		add_header(OP_LOAD, 32'h1000_0000, 32'd17, 32'hDEAD_BEEF, 1'b1);
		add_noise(32);
		add_header(OP_FILL, 32'h2000_0000, 32'd64, 32'hFFFF_0000, 1'b1);
		// Section ends inside a header
		add_noise(7);
		end_section();
		// Load length near the top: the skip must not wrap to zero
		add_header(OP_LOAD, 32'h3000_0000, 32'hFFFF_FFF1, 32'h0, 1'b1);
		add_noise(20);
		end_section();
		// Unknown opcode zero: a well-formed header after it is ignored
		add_header(8'h00, 32'h4000_0000, 32'h0, 32'h0, 1'b1);
		add_header(OP_JUMP, 32'h5000_0000, 32'h0, 32'h0, 1'b1);
		end_section();
		// Unknown opcodes one and all-ones, ending on the header itself
		add_header(8'h01, 32'h0, 32'h0, 32'h0, 1'b0);
		end_section();
		add_header(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		end_section();
		// Section ends inside a load payload
		add_header(OP_LOAD, 32'h6000_0000, 32'd40, 32'h0, 1'b1);
		add_noise(9);
		end_section();

		// Random sections, mostly well-formed command sequences
		while (total_items < 650) begin
			ncmd = $urandom_range(1, 6);
			open = 1'b1;
			for (int c = 0; c < ncmd && open; c++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					add_noise($urandom_range(1, 15));
					open = 1'b0;
				end else begin
					if (pick < 36)      op = OP_LOAD;
					else if (pick < 56) op = OP_FILL;
					else if (pick < 72) op = OP_CALL;
					else if (pick < 88) op = OP_JUMP;
					else                op = unknown_opcode();
					mid = $urandom;
					if (op == OP_LOAD)
						mid = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 200)
						                                   : $urandom_range(0, 48);
					add_header(op, $urandom, mid, $urandom, $urandom_range(0, 9) != 0);
					if (op == OP_LOAD) begin
						plen = (mid + 15) & ~15;
						if (plen > 0 && $urandom_range(0, 9) == 0) begin
							add_noise($urandom_range(1, plen - 1 > 0 ? plen - 1 : 1));
							open = 1'b0;
						end else begin
							add_noise(plen);
						end
					end else if (op != OP_FILL && op != OP_CALL && op != OP_JUMP) begin
						add_noise($urandom_range(0, 5));
						open = 1'b0;
					end
				end
			end
			end_section();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all bytes accepted, all records checked, then a short tail
		while (accepted_cnt != total_items)
			@(posedge clk);
		while (record_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
